// ===== rtl/tghd_pkg.sv =====
`timescale 1ns / 1ps

package tghd_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int LEVEL_BITS      = 10;
  localparam int LEVEL_MAX       = 1000;
  localparam int BASE_BITS       = 10;
  localparam int DIFF_BITS       = 11;
  localparam int COUNT_BITS      = 8;
  localparam int CFG_DATA_BITS   = 11;
  localparam int CFG_IDX_BITS    = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [BASE_BITS-1:0]  BASELINE_RST      = BASE_BITS'(0);
  localparam logic [DIFF_BITS-1:0]  ON_LEVEL_RST      = DIFF_BITS'(50);
  localparam logic [DIFF_BITS-1:0]  OFF_LEVEL_RST     = DIFF_BITS'(30);
  localparam logic [DIFF_BITS-1:0]  MIN_DELTA_RST     = DIFF_BITS'(20);
  localparam logic [COUNT_BITS-1:0] TREND_NEEDED_RST  = COUNT_BITS'(3);
  localparam logic [BASE_BITS-1:0]  STABLE_BAND_RST   = BASE_BITS'(5);
  localparam logic [COUNT_BITS-1:0] STABLE_NEEDED_RST = COUNT_BITS'(10);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BASELINE,
    REG_ON_LEVEL,
    REG_OFF_LEVEL,
    REG_MIN_DELTA,
    REG_TREND_NEEDED,
    REG_STABLE_BAND,
    REG_STABLE_NEEDED
  } cfg_index_t;

  typedef struct packed {
    logic [BASE_BITS-1:0]  baseline;
    logic [DIFF_BITS-1:0]  on_level;
    logic [DIFF_BITS-1:0]  off_level;
    logic [DIFF_BITS-1:0]  min_delta;
    logic [COUNT_BITS-1:0] trend_needed;
    logic [BASE_BITS-1:0]  stable_band;
    logic [COUNT_BITS-1:0] stable_needed;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [LEVEL_BITS-1:0] level;
  } level_beat_t;

endpackage

// ===== rtl/tghd_if.sv =====
`timescale 1ns / 1ps

interface tghd_sample_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tghd_result_if ();
  logic       valid;
  logic       ready;
  logic [9:0] level;
  logic       active;
  logic       done_res;

  modport source (output valid, output level, output active, output done_res, input ready);
  modport sink (input valid, input level, input active, input done_res, output ready);
endinterface

// ===== rtl/tghd_scale.sv =====
`timescale 1ns / 1ps

module tghd_scale import tghd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tghd_sample_if.sink  samples,
  output level_beat_t  beat,
  input  logic         beat_ready
);

  localparam int NW = SAMPLE_BITS + 11;
  localparam int MW = NW + 1;
  localparam int PW = NW + MW;
  localparam int K  = 2 * SAMPLE_BITS + 12;

  localparam longint unsigned FS    = (longint'(1) << SAMPLE_BITS) - 1;
  localparam longint unsigned DIV   = 2 * FS;
  localparam longint unsigned RECIP = (longint'(1) << K) / DIV;

  localparam logic [NW-1:0] FS_N    = NW'(FS);
  localparam logic [NW-1:0] DIV_N   = NW'(DIV);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  logic                   va;
  logic                   vb;
  logic                   vc;
  logic [SAMPLE_BITS-1:0] sa;
  logic [NW-1:0]          nb;
  logic [LEVEL_BITS-1:0]  qb;
  logic [LEVEL_BITS-1:0]  level;

  logic                   ready_a;
  logic                   ready_b;
  logic                   ready_c;
  logic [NW-1:0]          s_ext;
  logic [NW-1:0]          n;
  logic [PW-1:0]          prod;
  logic [LEVEL_BITS-1:0]  q_est;
  logic [NW-1:0]          qd;
  logic [NW-1:0]          rem;
  logic [LEVEL_BITS-1:0]  level_next;

  assign ready_c       = !vc || beat_ready;
  assign ready_b       = !vb || ready_c;
  assign ready_a       = !va || ready_b;
  assign samples.ready = ready_a;

  // The scaled numerator is sample * 2000 + FS; 2000 is formed as 2048 - 32 - 16.
  always_comb begin
    s_ext = NW'(sa);
    n     = (s_ext << 11) - (s_ext << 5) - (s_ext << 4) + FS_N;
    prod  = PW'(n) * PW'(RECIP_M);
    q_est = prod[K +: LEVEL_BITS];
  end

  // The reciprocal estimate is low by at most one; one compare corrects it.
  always_comb begin
    qd         = NW'(qb) * DIV_N;
    rem        = nb - qd;
    level_next = qb + LEVEL_BITS'(rem >= DIV_N);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ready_a) va <= samples.valid;
      if (ready_b) vb <= va;
      if (ready_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && samples.valid) sa <= samples.sample;
    if (ready_b && va) begin
      nb <= n;
      qb <= q_est;
    end
    if (ready_c && vb) level <= level_next;
  end

  assign beat.valid = vc;
  assign beat.level = level;

endmodule

// ===== rtl/tghd_detect.sv =====
`timescale 1ns / 1ps

module tghd_detect import tghd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  level_beat_t   beat,
  output logic          beat_ready,
  tghd_result_if.source results
);

  logic                  have_last;
  logic [LEVEL_BITS-1:0] last_level;
  logic [COUNT_BITS-1:0] rise_count;
  logic                  active_flag;
  logic                  ever_active;
  logic [COUNT_BITS-1:0] settle_count;
  logic                  done_flag;

  logic                  out_valid;
  logic [LEVEL_BITS-1:0] out_level;

  logic [LEVEL_BITS-1:0] change;
  logic [COUNT_BITS-1:0] rise_count_next;
  logic                  active_next;
  logic                  ever_active_next;
  logic [COUNT_BITS-1:0] settle_count_next;
  logic [COUNT_BITS-1:0] settle_step;
  logic                  done_flag_next;
  logic signed [11:0]    d;
  logic signed [11:0]    on_ext;
  logic signed [11:0]    off_ext;
  logic signed [11:0]    min_ext;
  logic                  take;

  assign beat_ready = !out_valid || results.ready;
  assign take       = beat.valid && beat_ready;

  always_comb begin
    d       = signed'({2'b00, beat.level}) - signed'({2'b00, cfg.baseline});
    on_ext  = 12'(signed'(cfg.on_level));
    off_ext = 12'(signed'(cfg.off_level));
    min_ext = 12'(signed'(cfg.min_delta));

    change          = '0;
    rise_count_next = rise_count;
    if (have_last) begin
      change = (beat.level > last_level) ? beat.level - last_level : last_level - beat.level;
      if (beat.level > last_level) begin
        rise_count_next = (rise_count == COUNT_MAX) ? rise_count : rise_count + 1'b1;
      end else begin
        rise_count_next = '0;
      end
    end

    if (active_flag) begin
      active_next = d > off_ext;
    end else begin
      active_next = (d > min_ext) && (rise_count_next >= cfg.trend_needed) && (d > on_ext);
    end

    ever_active_next  = ever_active || active_next;
    settle_count_next = active_next ? '0 : settle_count;
    done_flag_next    = done_flag;
    settle_step       = '0;
    if (ever_active && !active_next && !done_flag) begin
      if (change < cfg.stable_band) begin
        settle_step = (settle_count == COUNT_MAX) ? settle_count : settle_count + 1'b1;
      end
      settle_count_next = settle_step;
      done_flag_next    = settle_step >= cfg.stable_needed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last    <= 1'b0;
      last_level   <= '0;
      rise_count   <= '0;
      active_flag  <= 1'b0;
      ever_active  <= 1'b0;
      settle_count <= '0;
      done_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (beat_ready) out_valid <= beat.valid;
      if (take) begin
        have_last    <= 1'b1;
        last_level   <= beat.level;
        rise_count   <= rise_count_next;
        active_flag  <= active_next;
        ever_active  <= ever_active_next;
        settle_count <= settle_count_next;
        done_flag    <= done_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_level <= beat.level;
  end

  assign results.valid    = out_valid;
  assign results.level    = out_level;
  assign results.active   = active_flag;
  assign results.done_res = done_flag;

endmodule

// ===== rtl/trend_gated_hysteresis_detector.sv =====
`timescale 1ns / 1ps

// Trend-gated hysteresis detector.
// Raw converter samples arrive on the samples channel, one per transaction, and each
// produces exactly one transaction on the results channel: the sample scaled to
// thousandths of full scale, the hysteresis active flag and the sticky settle flag.
// Both channels use valid/ready; a transaction completes when both are high.
// Registers are written through wr_en, wr_index and wr_data; the user must write them
// only while the block is idle, which the block itself does not enforce. Writes to an
// unused index are ignored. An accepted sample passes through four registers to its
// result: an input register, the reciprocal multiply, the one-step quotient correction
// and the result register that also holds the detector state.
// Throughput is one sample per cycle. When the receiver stalls, the pipeline fills
// and then samples.ready drops; no transaction is lost.
// Synchronous reset empties the pipeline, clears all detector state and restores
// the register defaults.
module trend_gated_hysteresis_detector import tghd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  tghd_sample_if.sink              samples,
  tghd_result_if.source            results
);

  cfg_t        cfg;
  level_beat_t beat;
  logic        beat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline      <= BASELINE_RST;
      cfg.on_level      <= ON_LEVEL_RST;
      cfg.off_level     <= OFF_LEVEL_RST;
      cfg.min_delta     <= MIN_DELTA_RST;
      cfg.trend_needed  <= TREND_NEEDED_RST;
      cfg.stable_band   <= STABLE_BAND_RST;
      cfg.stable_needed <= STABLE_NEEDED_RST;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        REG_BASELINE:      cfg.baseline      <= wr_data[BASE_BITS-1:0];
        REG_ON_LEVEL:      cfg.on_level      <= wr_data[DIFF_BITS-1:0];
        REG_OFF_LEVEL:     cfg.off_level     <= wr_data[DIFF_BITS-1:0];
        REG_MIN_DELTA:     cfg.min_delta     <= wr_data[DIFF_BITS-1:0];
        REG_TREND_NEEDED:  cfg.trend_needed  <= wr_data[COUNT_BITS-1:0];
        REG_STABLE_BAND:   cfg.stable_band   <= wr_data[BASE_BITS-1:0];
        REG_STABLE_NEEDED: cfg.stable_needed <= wr_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  tghd_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  tghd_detect u_detect (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .beat       (beat),
    .beat_ready (beat_ready),
    .results    (results)
  );

endmodule
